// File: hdl/lbc_pkg.sv
// Shared types and outcome codes for the LRU block cache.
`timescale 1ns / 1ps

package lbc_pkg;

  localparam int unsigned DISK_W  = 8;
  localparam int unsigned BLOCK_W = 32;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SLOT_W  = 6;

  localparam logic ACTION_GET = 1'b0;
  localparam logic ACTION_PUT = 1'b1;

  typedef enum logic [2:0] {
    OUTCOME_GET_HIT  = 3'd0,
    OUTCOME_GET_MISS = 3'd1,
    OUTCOME_PUT_UPD  = 3'd2,
    OUTCOME_PUT_COLD = 3'd3,
    OUTCOME_PUT_EVICT = 3'd4
  } outcome_t;

  typedef struct packed {
    logic               action;
    logic [DISK_W-1:0]  disk_id;
    logic [BLOCK_W-1:0] block_id;
    logic [DATA_W-1:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [2:0]        outcome;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] read_data;
  } out_item_t;

endpackage

// File: hdl/lru_block_cache.sv
// Fully associative LRU block cache with a sequential tag and stamp scan.
`timescale 1ns / 1ps

// Fully associative cache of CACHE_ENTRIES words tagged by disk and block id,
// with least-recently-stamped replacement. Pulse start while busy is low to
// issue a get or put; the result appears on out_item for exactly one cycle
// with out_strobe high and must be taken then, since the block cannot be
// stalled. Each access walks the tag and stamp memories one slot per cycle,
// so busy stays high through the scan of every filled slot, a drain state
// and a resolve state (and a read state on a get hit), and the result comes
// in the same cycle that busy falls; an access to an empty cache goes from
// idle straight to resolve. The tag and stamp memories have a single read port.
// No clearing pass is needed after reset: only filled slots are ever read.
module lru_block_cache #(
  parameter int unsigned CACHE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lbc_pkg::in_item_t  in_item,
  output logic              out_strobe,
  output lbc_pkg::out_item_t out_item
);

  import lbc_pkg::*;

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned TAG_W = DISK_W + BLOCK_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CACHE_ENTRIES);
  localparam logic [STAMP_W-1:0] CLOCK_MAX = '1;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_DRAIN   = 5'b00100,
    ST_RESOLVE = 5'b01000,
    ST_READ    = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  in_item_t           req_r, req_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [STAMP_W-1:0] clock_r, clock_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   found_idx_r, found_idx_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [STAMP_W-1:0] best_stamp_r, best_stamp_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  out_item_t          out_item_r, out_item_nxt;

  // Memories and their registered read ports
  logic [TAG_W-1:0]   tag_mem   [CACHE_ENTRIES];
  logic [DATA_W-1:0]  data_mem  [CACHE_ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [CACHE_ENTRIES];
  logic [TAG_W-1:0]   tag_rd_r;
  logic [STAMP_W-1:0] stamp_rd_r;
  logic [DATA_W-1:0]  data_rd_r;

  logic               tag_we, data_we, stamp_we;
  logic [IDX_W-1:0]   wr_addr;
  logic               accept;
  logic               last_issue;
  logic               tag_match;
  logic [IDX_W-1:0]   victim_idx;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign last_issue = (CNT_W'(scan_idx_r) == CNT_W'(fill_r - CNT_W'(1)));
  assign tag_match  = (tag_rd_r == {req_r.disk_id, req_r.block_id});
  assign victim_idx = (fill_r < FULL_CNT) ? IDX_W'(fill_r) : best_idx_r;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    fill_nxt       = fill_r;
    clock_nxt      = clock_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_vld_nxt    = 1'b0;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    best_idx_nxt   = best_idx_r;
    best_stamp_nxt = best_stamp_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    tag_we         = 1'b0;
    data_we        = 1'b0;
    stamp_we       = 1'b0;
    wr_addr        = found_idx_r;

    // Compare stage: first match wins, strictly older stamp replaces best
    if (cmp_vld_r) begin
      if (tag_match && !found_r) begin
        found_nxt     = 1'b1;
        found_idx_nxt = cmp_idx_r;
      end
      if ((cmp_idx_r == '0) || (stamp_rd_r < best_stamp_r)) begin
        best_idx_nxt   = cmp_idx_r;
        best_stamp_nxt = stamp_rd_r;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt      = in_item;
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
          state_nxt    = (fill_r == '0) ? ST_RESOLVE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmp_vld_nxt = 1'b1;
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (clock_r != CLOCK_MAX) begin
          clock_nxt = clock_r + STAMP_W'(1);
        end
        out_item_nxt.read_data = '0;
        state_nxt = ST_IDLE;
        if (req_r.action == ACTION_GET) begin
          if (found_r) begin
            // Restamp now, fetch the word in ST_READ, then report it
            stamp_we  = 1'b1;
            state_nxt = ST_READ;
          end else begin
            out_strobe_nxt       = 1'b1;
            out_item_nxt.hit     = 1'b0;
            out_item_nxt.outcome = OUTCOME_GET_MISS;
            out_item_nxt.slot    = '0;
          end
        end else if (found_r) begin
          data_we              = 1'b1;
          out_strobe_nxt       = 1'b1;
          out_item_nxt.hit     = 1'b1;
          out_item_nxt.outcome = OUTCOME_PUT_UPD;
          out_item_nxt.slot    = SLOT_W'(found_idx_r);
        end else begin
          wr_addr              = victim_idx;
          tag_we               = 1'b1;
          data_we              = 1'b1;
          stamp_we             = 1'b1;
          out_strobe_nxt       = 1'b1;
          out_item_nxt.hit     = 1'b0;
          out_item_nxt.slot    = SLOT_W'(victim_idx);
          if (fill_r < FULL_CNT) begin
            fill_nxt             = fill_r + CNT_W'(1);
            out_item_nxt.outcome = OUTCOME_PUT_COLD;
          end else begin
            out_item_nxt.outcome = OUTCOME_PUT_EVICT;
          end
        end
      end
      ST_READ: begin
        out_strobe_nxt         = 1'b1;
        out_item_nxt.hit       = 1'b1;
        out_item_nxt.outcome   = OUTCOME_GET_HIT;
        out_item_nxt.slot      = SLOT_W'(found_idx_r);
        out_item_nxt.read_data = data_rd_r;
        state_nxt              = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      clock_r      <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      clock_r      <= clock_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      found_r      <= found_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= scan_idx_r;
    found_idx_r  <= found_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    out_item_r   <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_addr] <= {req_r.disk_id, req_r.block_id};
    end
    if (data_we) begin
      data_mem[wr_addr] <= req_r.write_data;
    end
    if (stamp_we) begin
      stamp_mem[wr_addr] <= clock_r;
    end
    tag_rd_r   <= tag_mem[scan_idx_r];
    stamp_rd_r <= stamp_mem[scan_idx_r];
    data_rd_r  <= data_mem[found_idx_r];
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count exceeds cache size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result strobe held for more than one cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && (out_item_r.outcome == OUTCOME_GET_MISS) |->
      !out_item_r.hit && (out_item_r.slot == '0) && (out_item_r.read_data == '0))
    else $error("get miss carries nonzero fields");

  a_resolve_clock: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESOLVE) && (clock_r != CLOCK_MAX) |=> clock_r == $past(clock_r) + 1)
    else $error("access clock did not advance");
`endif

endmodule
